/* rtl/core/vhcs_pkg.sv */
package vhcs_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;

  localparam int ColumnW = 10;
  localparam int DepthW  = 16;
  localparam int HeightW = 8;
  localparam int ColorW  = 24;
  localparam int TopW    = 10;
  localparam int RowW    = 11;

  localparam int CfgW    = 11;
  localparam int CfgIdxW = 2;

  localparam int EyeW   = 10;
  localparam int ScaleW = 10;
  localparam int PitchW = 11;

  // |eye - height| * scale * 16 fits in 24 bits
  localparam int NumW     = 24;
  localparam int DivSteps = NumW;
  // sign + quotient + headroom for the pitch add
  localparam int RowSumW  = NumW + 2;

  localparam logic [DepthW-1:0] MinDepth = DepthW'(16);

  localparam logic [EyeW-1:0]   EyeHeightReset   = EyeW'(200);
  localparam logic [ScaleW-1:0] HeightScaleReset = ScaleW'(500);
  localparam logic [PitchW-1:0] PitchOffsetReset = '0;
  localparam logic [RowW-1:0]   ScreenRowsReset  = RowW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EYE_HEIGHT,
    CFG_HEIGHT_SCALE,
    CFG_PITCH_OFFSET,
    CFG_SCREEN_ROWS
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/vhcs_sample_if.sv */
interface vhcs_sample_if;
  logic                        valid;
  logic                        ready;
  logic [vhcs_pkg::ColumnW-1:0] column;
  logic                        first_of_column;
  logic [vhcs_pkg::DepthW-1:0]  corrected_depth;
  logic [vhcs_pkg::HeightW-1:0] cell_height;
  logic [vhcs_pkg::ColorW-1:0]  cell_color;

  modport source (
    output valid, column, first_of_column, corrected_depth, cell_height, cell_color,
    input  ready
  );
  modport sink (
    input  valid, column, first_of_column, corrected_depth, cell_height, cell_color,
    output ready
  );
endinterface

/* rtl/core/vhcs_span_if.sv */
interface vhcs_span_if;
  logic                        valid;
  logic                        ready;
  logic [vhcs_pkg::ColumnW-1:0] span_column;
  logic [vhcs_pkg::TopW-1:0]    span_top;
  logic [vhcs_pkg::RowW-1:0]    span_bottom;
  logic [vhcs_pkg::ColorW-1:0]  span_color;

  modport source (
    output valid, span_column, span_top, span_bottom, span_color,
    input  ready
  );
  modport sink (
    input  valid, span_column, span_top, span_bottom, span_color,
    output ready
  );
endinterface

/* rtl/core/voxel_heightmap_column_span.sv */
// Flow: a sample is taken in IDLE, MUL forms the numerator, DIV runs the
// 24-step radix-2 divider and DONE registers the span. No new sample is taken
// until the last one has left DONE, which waits while a finished span waits for the sink.
// Reset (rst, synchronous): control and configuration registers return to
// defaults; the occlusion memory is not cleared, first_of_column seeds it.
module voxel_heightmap_column_span #(
  parameter int MAX_COLUMNS = vhcs_pkg::MaxColumns,
  parameter int MAX_ROWS    = vhcs_pkg::MaxRows
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [vhcs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vhcs_pkg::CfgW-1:0]    cfg_data,
  vhcs_sample_if.sink                  sample,
  vhcs_span_if.source                  span
);

  localparam int AddrW = $clog2(MAX_COLUMNS);
  localparam int CntW  = $clog2(vhcs_pkg::DivSteps);
  localparam int NumW  = vhcs_pkg::NumW;
  localparam int SumW  = vhcs_pkg::RowSumW;
  localparam int RowW  = vhcs_pkg::RowW;
  localparam int DepW  = vhcs_pkg::DepthW;
  localparam int ProdW = vhcs_pkg::EyeW + vhcs_pkg::ScaleW;

  // configuration
  logic [vhcs_pkg::EyeW-1:0]          eye_height;
  logic [vhcs_pkg::ScaleW-1:0]        height_scale;
  logic signed [vhcs_pkg::PitchW-1:0] pitch_offset;
  logic [RowW-1:0]                    screen_rows;
  logic [RowW-1:0]                    eff_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_height   <= vhcs_pkg::EyeHeightReset;
      height_scale <= vhcs_pkg::HeightScaleReset;
      pitch_offset <= vhcs_pkg::PitchOffsetReset;
      screen_rows  <= vhcs_pkg::ScreenRowsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        vhcs_pkg::CFG_EYE_HEIGHT:   eye_height   <= cfg_data[vhcs_pkg::EyeW-1:0];
        vhcs_pkg::CFG_HEIGHT_SCALE: height_scale <= cfg_data[vhcs_pkg::ScaleW-1:0];
        vhcs_pkg::CFG_PITCH_OFFSET: pitch_offset <= cfg_data[vhcs_pkg::PitchW-1:0];
        vhcs_pkg::CFG_SCREEN_ROWS:  screen_rows  <= cfg_data[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (screen_rows == '0) begin
      eff_rows = RowW'(1);
    end else if (int'(screen_rows) > MAX_ROWS) begin
      eff_rows = RowW'(MAX_ROWS);
    end else begin
      eff_rows = screen_rows;
    end
  end

  // control
  vhcs_pkg::state_t state, state_next;
  logic [CntW-1:0]  cnt;
  logic             accept;
  logic             out_free;
  logic             finish;
  logic             hit;
  logic             mem_we;

  assign accept   = sample.valid && sample.ready;
  assign out_free = !span.valid || span.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vhcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    finish       = 1'b0;
    case (state)
      vhcs_pkg::ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) state_next = vhcs_pkg::ST_MUL;
      end
      vhcs_pkg::ST_MUL: begin
        state_next = vhcs_pkg::ST_DIV;
      end
      vhcs_pkg::ST_DIV: begin
        if (cnt == CntW'(vhcs_pkg::DivSteps - 1)) state_next = vhcs_pkg::ST_DONE;
      end
      vhcs_pkg::ST_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = vhcs_pkg::ST_IDLE;
        end
      end
      default: state_next = vhcs_pkg::ST_IDLE;
    endcase
  end

  // captured sample
  logic [vhcs_pkg::ColumnW-1:0] col_q;
  logic [AddrW-1:0]             addr_q;
  logic                         first_q;
  logic                         skip_q;
  logic [DepW-1:0]              depth_q;
  logic [vhcs_pkg::HeightW-1:0] height_q;
  logic [vhcs_pkg::ColorW-1:0]  color_q;
  logic                         in_range;

  assign in_range = int'(sample.column) < MAX_COLUMNS;

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q    <= sample.column;
      addr_q   <= AddrW'(sample.column);
      first_q  <= sample.first_of_column;
      skip_q   <= !in_range;
      depth_q  <= (sample.corrected_depth < vhcs_pkg::MinDepth) ?
                  vhcs_pkg::MinDepth : sample.corrected_depth;
      height_q <= sample.cell_height;
      color_q  <= sample.cell_color;
    end
  end

  // occlusion memory, registered read
  logic [RowW-1:0] occ_mem [MAX_COLUMNS];
  logic [RowW-1:0] rd_data;
  logic [RowW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (accept && in_range) rd_data <= occ_mem[AddrW'(sample.column)];
    if (mem_we) occ_mem[addr_q] <= wr_data;
  end

  // numerator magnitude: |eye - height| * scale * 16
  logic signed [vhcs_pkg::EyeW:0] diff;
  logic [vhcs_pkg::EyeW:0]        diff_mag;
  logic [ProdW-1:0]               prod;
  logic                           neg;
  logic [NumW-1:0]                dq;
  logic [DepW:0]                  rem;
  logic [DepW:0]                  rem_sh;
  logic                           ge;

  assign diff     = $signed({1'b0, eye_height}) - $signed({3'b000, height_q});
  assign diff_mag = diff[vhcs_pkg::EyeW] ? -diff : diff;
  assign prod     = ProdW'(diff_mag[vhcs_pkg::EyeW-1:0]) * ProdW'(height_scale);
  assign rem_sh   = {rem[DepW-1:0], dq[NumW-1]};
  assign ge       = rem_sh >= {1'b0, depth_q};

  always_ff @(posedge clk) begin
    case (state)
      vhcs_pkg::ST_MUL: begin
        neg <= diff[vhcs_pkg::EyeW];
        dq  <= {prod, 4'b0000};
        rem <= '0;
        cnt <= '0;
      end
      vhcs_pkg::ST_DIV: begin
        rem <= ge ? rem_sh - {1'b0, depth_q} : rem_sh;
        dq  <= {dq[NumW-2:0], ge};
        cnt <= cnt + CntW'(1);
      end
      default: ;
    endcase
  end

  // projected row, clamp, occlusion test
  logic signed [SumW-1:0] quot_s;
  logic signed [SumW-1:0] row_s;
  logic [SumW-1:0]        row_c;
  logic [RowW-1:0]        limit;

  always_comb begin
    quot_s  = neg ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
    row_s   = quot_s + SumW'(pitch_offset);
    row_c   = row_s[SumW-1] ? '0 : row_s;
    limit   = first_q ? eff_rows : rd_data;
    hit     = !skip_q && (row_c < SumW'(limit));
    mem_we  = finish && !skip_q && (first_q || hit);
    wr_data = hit ? row_c[RowW-1:0] : limit;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      span.valid <= 1'b0;
    end else if (finish) begin
      span.valid <= hit;
    end else if (span.ready) begin
      span.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && hit) begin
      span.span_column <= col_q;
      span.span_top    <= row_c[vhcs_pkg::TopW-1:0];
      span.span_bottom <= limit;
      span.span_color  <= color_q;
    end
  end

endmodule

/* dv/voxel_heightmap_column_span_checker.sv */
`timescale 1ns / 100ps
module voxel_heightmap_column_span_checker
  import vhcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  vhcs_sample_if             sample_ch,
  vhcs_span_if               span_ch,
  output int                 fail_count,
  output int                 pending,
  output int                 spans_seen
);

  typedef struct packed {
    logic [ColumnW-1:0] column;
    logic [TopW-1:0]    top;
    logic [RowW-1:0]    bottom;
    logic [ColorW-1:0]  color;
  } span_t;

  logic [EyeW-1:0]          eye_r;
  logic [ScaleW-1:0]        scale_r;
  logic signed [PitchW-1:0] pitch_r;
  logic [RowW-1:0]          rows_r;
  // topmost row painted so far, per column
  logic [RowW-1:0]          top_painted [MaxColumns];
  span_t                    span_q [$];
  int                       fails   = 0;
  int                       queued  = 0;
  int                       checked = 0;

  assign fail_count = fails;
  assign pending    = queued;
  assign spans_seen = checked;

  function automatic bit project_span(input logic [ColumnW-1:0] col, input logic first,
                                      input logic [DepthW-1:0] depth,
                                      input logic [HeightW-1:0] height,
                                      input logic [ColorW-1:0] color, output span_t s);
    longint num;
    longint divisor;
    longint row;
    longint limit;
    s = '0;
    if (first) begin
      top_painted[col] = (rows_r == 0) ? RowW'(1) :
                         (rows_r > MaxRows) ? RowW'(MaxRows) : rows_r;
    end
    divisor = (depth < MinDepth) ? longint'(MinDepth) : longint'(depth);
    num = (longint'(eye_r) - longint'(height)) * longint'(scale_r) * 16;
    // signed division truncates toward zero
    row = num / divisor + longint'(pitch_r);
    if (row < 0) row = 0;
    limit = longint'(top_painted[col]);
    if (row >= limit) return 1'b0;
    s.column = col;
    s.top    = TopW'(row);
    s.bottom = RowW'(limit);
    s.color  = color;
    top_painted[col] = RowW'(row);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    span_t want;
    if (rst) begin
      eye_r   = EyeHeightReset;
      scale_r = HeightScaleReset;
      pitch_r = PitchOffsetReset;
      rows_r  = ScreenRowsReset;
      span_q.delete();
    end else begin
      if (span_ch.valid && span_ch.ready) begin
        checked++;
        if (span_q.size() == 0) begin
          $error("span with nothing expected: column %0d top %0d bottom %0d color %06h",
                 span_ch.span_column, span_ch.span_top, span_ch.span_bottom,
                 span_ch.span_color);
          fails++;
        end else begin
          want = span_q.pop_front();
          check_field("span_column", want.column, span_ch.span_column);
          check_field("span_top", want.top, span_ch.span_top);
          check_field("span_bottom", want.bottom, span_ch.span_bottom);
          check_field("span_color", want.color, span_ch.span_color);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_EYE_HEIGHT:   eye_r   = EyeW'(cfg_data);
          CFG_HEIGHT_SCALE: scale_r = ScaleW'(cfg_data);
          CFG_PITCH_OFFSET: pitch_r = PitchW'(cfg_data);
          CFG_SCREEN_ROWS:  rows_r  = RowW'(cfg_data);
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        if (project_span(sample_ch.column, sample_ch.first_of_column,
                         sample_ch.corrected_depth, sample_ch.cell_height,
                         sample_ch.cell_color, want)) begin
          span_q.push_back(want);
        end
      end
    end
    queued = span_q.size();
  end

endmodule

/* dv/voxel_heightmap_column_span_tb.sv */
`timescale 1ns / 100ps
module voxel_heightmap_column_span_tb;
  import vhcs_pkg::*;

  localparam int ClkPeriod    = 4;
  localparam int RandomItems  = 1950;
  localparam int PhaseItems   = 195;
  localparam int SettleCycles = 40;
  localparam int DrainLimit   = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  int fail_count;
  int pending;
  int spans_seen;
  int samples_sent  = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int stall_left    = 0;
  int ready_cycle   = 0;
  bit no_gaps       = 1'b0;
  bit seeded [MaxColumns];

  vhcs_sample_if sample_ch ();
  vhcs_span_if   span_ch ();

  voxel_heightmap_column_span u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .span      (span_ch)
  );

  voxel_heightmap_column_span_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_ch  (sample_ch),
    .span_ch    (span_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .spans_seen (spans_seen)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    #(ClkPeriod * 1_000_000);
    $display("[voxel_heightmap_column_span] ERROR");
    $finish;
  end

  // span sink: free-flowing, short random stalls, then rare long stalls
  always @(negedge clk) begin
    ready_cycle++;
    if (stall_left == 0) begin
      case ((ready_cycle / 600) % 3)
        1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
        2: if ($urandom_range(0, 24) == 0) stall_left = $urandom_range(10, 60);
        default: ;
      endcase
    end
    if (stall_left > 0) begin
      span_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      span_ch.ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [ColumnW-1:0] col, input logic first,
                             input logic [DepthW-1:0] depth, input logic [HeightW-1:0] height,
                             input logic [ColorW-1:0] color);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    sample_ch.valid           <= 1'b1;
    sample_ch.column          <= col;
    sample_ch.first_of_column <= first;
    sample_ch.corrected_depth <= depth;
    sample_ch.cell_height     <= height;
    sample_ch.cell_color      <= color;
    do @(posedge clk); while (!sample_ch.ready);
    if (first) seeded[col] = 1'b1;
    samples_sent++;
  endtask

  // only with the block drained; a sample may still be in the divider with no span due
  task automatic write_settings(input logic [EyeW-1:0] eye, input logic [ScaleW-1:0] scale,
                                input logic [PitchW-1:0] pitch, input logic [RowW-1:0] rows);
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EYE_HEIGHT;
    cfg_data  <= CfgW'(eye);
    @(negedge clk);
    cfg_index <= CFG_HEIGHT_SCALE;
    cfg_data  <= CfgW'(scale);
    @(negedge clk);
    cfg_index <= CFG_PITCH_OFFSET;
    cfg_data  <= CfgW'(pitch);
    @(negedge clk);
    cfg_index <= CFG_SCREEN_ROWS;
    cfg_data  <= CfgW'(rows);
    @(negedge clk);
    cfg_we <= 1'b0;
    burst_left = 0;
    settings_used++;
  endtask

  initial begin
    logic [ColumnW-1:0] col;
    logic [DepthW-1:0]  depth;
    logic [HeightW-1:0] height;
    int                 len;
    int                 phase_end;
    int                 random_sent;
    int                 next_depth;
    int                 next_height;
    int                 drain;

    random_sent               = 0;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_EYE_HEIGHT;
    cfg_data                  = '0;
    sample_ch.valid           = 1'b0;
    sample_ch.column          = '0;
    sample_ch.first_of_column = 1'b0;
    sample_ch.corrected_depth = '0;
    sample_ch.cell_height     = '0;
    sample_ch.cell_color      = '0;
    span_ch.ready             = 1'b0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // defaults after reset: eye 200, scale 500, pitch 0, 480 rows
    send_sample(10'd0, 1'b1, 16'd16, 8'd200, 24'h000000);
    send_sample(10'd1023, 1'b1, 16'd0, 8'd255, 24'hffffff);
    send_sample(10'd5, 1'b1, 16'hffff, 8'd0, 24'h123456);
    send_sample(10'd5, 1'b0, 16'hffff, 8'd0, 24'h654321);   // row equals occlusion
    send_sample(10'd5, 1'b0, 16'd16, 8'd0, 24'h00ff00);     // projects below screen
    send_sample(10'd5, 1'b0, 16'd15, 8'd199, 24'h0000ff);   // depth under 1.0
    send_sample(10'd5, 1'b0, 16'd8000, 8'd190, 24'haaaaaa);
    send_sample(10'd5, 1'b1, 16'd8000, 8'd190, 24'h555555);
    send_sample(10'd1023, 1'b0, 16'd16, 8'd0, 24'h0f0f0f);

    // bottom row of a 1024-row screen; row count above the maximum
    write_settings(10'd0, 10'd1023, 11'd1023, 11'd2047);
    send_sample(10'd7, 1'b1, 16'd16, 8'd0, 24'h800001);
    send_sample(10'd7, 1'b0, 16'd16, 8'd255, 24'h7ffffe);
    send_sample(10'd7, 1'b0, 16'd200, 8'd10, 24'h010203);

    // most negative pitch, zero rows used as one
    write_settings(10'd1023, 10'd1, 11'h400, 11'd0);
    send_sample(10'd8, 1'b1, 16'd16, 8'd0, 24'hc0ffee);
    send_sample(10'd8, 1'b0, 16'd16, 8'd0, 24'h00beef);

    write_settings(10'd1023, 10'd1023, 11'd100, 11'd1024);
    send_sample(10'd9, 1'b1, 16'hffff, 8'd0, 24'h112233);
    send_sample(10'd9, 1'b0, 16'd0, 8'd255, 24'h445566);

    // negative quotient truncates toward zero before the pitch add
    write_settings(10'd0, 10'd7, 11'd10, 11'd480);
    send_sample(10'd11, 1'b1, 16'd48, 8'd1, 24'h778899);
    send_sample(10'd11, 1'b0, 16'd48, 8'd255, 24'haabbcc);

    write_settings(10'd512, 10'd0, 11'd5, 11'd6);
    send_sample(10'd12, 1'b1, 16'd1000, 8'd50, 24'hddeeff);

    while (random_sent < RandomItems) begin
      if (settings_used % 4 == 0) begin
        write_settings(EyeW'($urandom), ScaleW'($urandom), PitchW'($urandom),
                       RowW'($urandom));
      end else begin
        write_settings(EyeW'($urandom_range(100, 500)), ScaleW'($urandom_range(100, 900)),
                       PitchW'(int'($urandom_range(0, 400)) - 100),
                       RowW'($urandom_range(200, 1024)));
      end
      no_gaps = (settings_used % 3 == 0);
      phase_end = random_sent + PhaseItems;
      while (random_sent < phase_end) begin
        col = ColumnW'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          send_sample(col, seeded[col] ? 1'($urandom_range(0, 1)) : 1'b1, DepthW'($urandom),
                      HeightW'($urandom), ColorW'($urandom));
          random_sent++;
        end else begin
          // one ray, front to back: depth grows, terrain height wanders
          len    = $urandom_range(2, 20);
          depth  = DepthW'($urandom_range(0, 2000));
          height = HeightW'($urandom);
          for (int k = 0; k < len; k++) begin
            send_sample(col, k == 0, depth, height, ColorW'($urandom));
            random_sent++;
            next_depth  = int'(depth) + int'(depth) / 4 + int'($urandom_range(1, 200));
            depth       = (next_depth > 65535) ? '1 : DepthW'(next_depth);
            next_height = int'(height) + int'($urandom_range(0, 60)) - 30;
            height      = (next_height < 0) ? '0 :
                          (next_height > 255) ? '1 : HeightW'(next_height);
          end
        end
      end
    end

    @(negedge clk);
    sample_ch.valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DrainLimit) begin
      @(negedge clk);
      drain++;
    end
    repeat (SettleCycles) @(negedge clk);

    $display("Run covered %0d samples under %0d register settings, %0d spans compared.",
             samples_sent, settings_used, spans_seen);
    $display("Field mismatches: %0d, spans never delivered: %0d.", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[voxel_heightmap_column_span] OK");
    end else begin
      $display("[voxel_heightmap_column_span] ERROR");
    end
    $finish;
  end

endmodule
